[hw/rtl/ltct_pkg.sv]
// Shared types, codes and constants of the lambda term count table.
package ltct_pkg;

  localparam int CNT_W  = 63;
  localparam int CELL_W = CNT_W + 1;
  localparam int HALF_W = 32;
  localparam int PP_W   = 2 * HALF_W;
  localparam int PROD_W = 2 * CNT_W;

  localparam logic [CNT_W-1:0] SAT_MAX = '1;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [4:0] query_size;
    logic [4:0] query_free_vars;
  } ltct_in_t;

  typedef struct packed {
    logic [CNT_W-1:0] term_count;
    logic             allowed;
    logic             saturated;
  } ltct_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUERY,
    ST_B_CELL,
    ST_B_BASE,
    ST_B_RDB,
    ST_B_MUL0,
    ST_B_MUL,
    ST_B_PADD,
    ST_B_ACC,
    ST_B_DONE
  } ltct_state_t;

endpackage

[hw/rtl/lambda_term_count_table.sv]
// Top level of the lambda term count table: build sequencer, query path and result register.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid, in_stall  | in_data  (ltct_in_t)
//   out     | out | out_valid, out_stall| out_data (ltct_out_t)
//
// A query transaction performs one RAM read and then loads the result register.
// A build transaction walks all cells once; each computed cell of size n sums n terms
// (one read port, one 32x32 multiplier used for four partial products per term),
// and every other cell is written directly.
// After reset the table reads as zero until the first build completes.
// A new transaction is accepted while a finished result waits under out_stall.
module lambda_term_count_table #(
  parameter int MAX_SIZE      = 16,
  parameter int MAX_FREE_VARS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ltct_pkg::ltct_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ltct_pkg::ltct_out_t  out_data
);
  import ltct_pkg::*;

  localparam int ROWS  = MAX_SIZE + 1;
  localparam int COLS  = MAX_FREE_VARS + 1;
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(ROWS);
  localparam int MW    = $clog2(COLS);

  function automatic logic [AW-1:0] cell_addr(input int n, input int m);
    return AW'(n * COLS + m);
  endfunction

  ltct_state_t state_r, state_nxt;

  logic [NW-1:0]     n_r, i_r, n_adv;
  logic [MW-1:0]     m_r, m_adv;
  logic [1:0]        k_r, pp_k_r;
  logic              base_ok_r, q_ok_r, built_r, built_nxt;
  logic [CNT_W-1:0]  acc_r, a_r, b_r;
  logic              mark_r, a_mark_r, b_mark_r;
  logic [PP_W-1:0]   pp_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r, out_valid_nxt;
  ltct_out_t         out_data_r, out_load_data;
  logic              out_load, out_free;

  logic              ram_wr_en, ram_rd_en;
  logic [AW-1:0]     ram_wr_addr, ram_rd_addr, q_addr;
  logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

  logic              in_accept, q_allowed, trivial_cell, base_ok_now, last_cell, last_i;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [PP_W-1:0]   mul_p;
  logic [PROD_W-1:0] pp_shifted, prod_sum;
  logic              p_clip, a_clip, mark_new;
  logic [CNT_W-1:0]  p_val, acc_new;
  logic [CNT_W:0]    sum_wide;

  ltct_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign q_allowed = (int'(in_data.query_size) <= MAX_SIZE) &&
                     (int'(in_data.query_free_vars) <= MAX_FREE_VARS) &&
                     (int'(in_data.query_size) + int'(in_data.query_free_vars) <= MAX_SIZE);
  assign q_addr    = q_allowed ?
                     cell_addr(int'(in_data.query_size), int'(in_data.query_free_vars)) : '0;

  assign trivial_cell = (n_r == '0) || (int'(n_r) + int'(m_r) > MAX_SIZE);
  assign base_ok_now  = (int'(m_r) + 1 <= MAX_FREE_VARS);
  assign last_cell    = (int'(n_r) == MAX_SIZE) && (int'(m_r) == MAX_FREE_VARS);
  assign last_i       = (int'(i_r) == int'(n_r) - 1);

  always_comb begin
    if (int'(m_r) == MAX_FREE_VARS) begin
      m_adv = '0;
      n_adv = n_r + 1'b1;
    end else begin
      m_adv = m_r + 1'b1;
      n_adv = n_r;
    end
  end

  always_comb begin
    case (k_r)
      2'd0: begin
        mul_a = a_r[HALF_W-1:0];
        mul_b = b_r[HALF_W-1:0];
      end
      2'd1: begin
        mul_a = a_r[HALF_W-1:0];
        mul_b = {1'b0, b_r[CNT_W-1:HALF_W]};
      end
      2'd2: begin
        mul_a = {1'b0, a_r[CNT_W-1:HALF_W]};
        mul_b = b_r[HALF_W-1:0];
      end
      default: begin
        mul_a = {1'b0, a_r[CNT_W-1:HALF_W]};
        mul_b = {1'b0, b_r[CNT_W-1:HALF_W]};
      end
    endcase
  end

  assign mul_p = PP_W'(mul_a) * PP_W'(mul_b);

  always_comb begin
    case (pp_k_r) inside
      2'd0:       pp_shifted = PROD_W'(pp_r);
      2'd1, 2'd2: pp_shifted = PROD_W'(pp_r) << HALF_W;
      default:    pp_shifted = PROD_W'(pp_r) << (2 * HALF_W);
    endcase
  end

  assign prod_sum = prod_r + pp_shifted;
  assign p_clip   = |prod_r[PROD_W-1:CNT_W];
  assign p_val    = p_clip ? SAT_MAX : prod_r[CNT_W-1:0];
  assign sum_wide = {1'b0, acc_r} + {1'b0, p_val};
  assign a_clip   = sum_wide[CNT_W];
  assign acc_new  = a_clip ? SAT_MAX : sum_wide[CNT_W-1:0];
  assign mark_new = mark_r || p_clip || a_clip || ((a_mark_r || b_mark_r) && (p_val != '0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.mode == MODE_BUILD) ? ST_B_CELL : ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_B_CELL: begin
        if (trivial_cell) begin
          state_nxt = last_cell ? ST_B_DONE : ST_B_CELL;
        end else begin
          state_nxt = ST_B_BASE;
        end
      end
      ST_B_BASE: state_nxt = ST_B_RDB;
      ST_B_RDB:  state_nxt = ST_B_MUL0;
      ST_B_MUL0: state_nxt = ST_B_MUL;
      ST_B_MUL: begin
        if (k_r == 2'd3) begin
          state_nxt = ST_B_PADD;
        end
      end
      ST_B_PADD: state_nxt = ST_B_ACC;
      ST_B_ACC: begin
        if (last_i) begin
          state_nxt = last_cell ? ST_B_DONE : ST_B_CELL;
        end else begin
          state_nxt = ST_B_RDB;
        end
      end
      ST_B_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cell_addr(int'(n_r), int'(m_r));
    ram_wr_data   = '0;
    out_load      = 1'b0;
    out_load_data = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        ram_rd_en   = in_valid;
        ram_rd_addr = q_addr;
      end
      ST_QUERY: begin
        out_load                 = out_free;
        out_load_data.allowed    = q_ok_r;
        out_load_data.term_count = (q_ok_r && built_r) ? ram_rd_data[CNT_W-1:0] : '0;
        out_load_data.saturated  = q_ok_r && built_r && ram_rd_data[CELL_W-1];
      end
      ST_B_CELL: begin
        if (trivial_cell) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = (n_r == '0) ? CELL_W'(m_r) : '0;
        end else begin
          ram_rd_en   = base_ok_now;
          ram_rd_addr = base_ok_now ? cell_addr(int'(n_r) - 1, int'(m_r) + 1) : '0;
        end
      end
      ST_B_BASE: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cell_addr(0, int'(m_r));
      end
      ST_B_RDB: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cell_addr(int'(n_r) - 1 - int'(i_r), int'(m_r));
      end
      ST_B_ACC: begin
        if (last_i) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = {mark_new, acc_new};
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = cell_addr(int'(i_r) + 1, int'(m_r));
        end
      end
      ST_B_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign built_nxt     = built_r || (state_r == ST_B_DONE && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      built_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      built_r     <= built_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          q_ok_r <= q_allowed;
          n_r    <= '0;
          m_r    <= '0;
        end
      end
      ST_B_CELL: begin
        base_ok_r <= base_ok_now;
        i_r       <= '0;
        if (trivial_cell) begin
          n_r <= n_adv;
          m_r <= m_adv;
        end
      end
      ST_B_BASE: begin
        acc_r  <= base_ok_r ? ram_rd_data[CNT_W-1:0] : '0;
        mark_r <= base_ok_r && ram_rd_data[CELL_W-1] && (|ram_rd_data[CNT_W-1:0]);
      end
      ST_B_RDB: begin
        a_r      <= ram_rd_data[CNT_W-1:0];
        a_mark_r <= ram_rd_data[CELL_W-1];
      end
      ST_B_MUL0: begin
        b_r      <= ram_rd_data[CNT_W-1:0];
        b_mark_r <= ram_rd_data[CELL_W-1];
        k_r      <= '0;
      end
      ST_B_MUL: begin
        pp_r   <= mul_p;
        pp_k_r <= k_r;
        k_r    <= k_r + 1'b1;
        prod_r <= (k_r == 2'd0) ? '0 : prod_sum;
      end
      ST_B_PADD: begin
        prod_r <= prod_sum;
      end
      ST_B_ACC: begin
        acc_r  <= acc_new;
        mark_r <= mark_new;
        if (last_i) begin
          n_r <= n_adv;
          m_r <= m_adv;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_wr_en)
    else $error("table written while idle");

  a_query_goes_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.mode == MODE_QUERY) |=> (state_r == ST_QUERY))
    else $error("query transaction did not start a table read");

  a_disallowed_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.allowed ||
                     (out_data_r.term_count == '0 && !out_data_r.saturated)))
    else $error("disallowed result carries a count or a mark");

  a_term_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_B_ACC) |-> (i_r < n_r))
    else $error("term index past the cell size");

endmodule

[hw/rtl/ltct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ltct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 289
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
